/* sv/p2c_pkg.sv */
// ----------------------------------------------------------------------------
// p2c_pkg: shared types and constants for polar to cartesian gridding
// Fixed-point formats, pipeline item types and the divider and CORDIC steps.
// ----------------------------------------------------------------------------
package p2c_pkg;

  // configuration register widths
  localparam int PQ_W  = 11;
  localparam int DIM_W = 12;
  localparam int CFG_W = 12;
  localparam int IDX_W = 11;

  // register limits
  localparam logic [PQ_W-1:0] PQ_MAX = 11'd1024;

  // reset values
  localparam logic [PQ_W-1:0]  P_RESET = 11'd200;
  localparam logic [PQ_W-1:0]  Q_RESET = 11'd100;
  localparam logic [DIM_W-1:0] H_RESET = 12'd200;
  localparam logic [DIM_W-1:0] W_RESET = 12'd200;

  // register index codes
  typedef enum logic [1:0] {
    CFG_NUM_PROJ   = 2'd0,
    CFG_HALF_PTS   = 2'd1,
    CFG_GRID_ROWS  = 2'd2,
    CFG_GRID_COLS  = 2'd3
  } cfg_reg_e;

  // divider: 18 quotient bits, remainder below twice the divisor
  localparam int QUOT_W    = 18;
  localparam int DIV_STEPS = QUOT_W;
  localparam int REM_W     = DIM_W + 1;

  // coordinates Q2.16, cordic datapath and angle in units of pi (Q1.17)
  localparam int COORD_W      = 18;
  localparam int XY_W         = 21;
  localparam int Z_W          = 20;
  localparam int CORDIC_STEPS = 18;
  localparam int STEP_W       = 5;

  localparam logic signed [Z_W-1:0] HALF_PI = 20'sd65536;

  localparam logic [16:0] ATAN_TAB [32] = '{
    17'd32768, 17'd19344, 17'd10221, 17'd5188, 17'd2604, 17'd1303, 17'd652, 17'd326,
    17'd163, 17'd81, 17'd41, 17'd20, 17'd10, 17'd5, 17'd3, 17'd1,
    17'd1, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0,
    17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0
  };

  // one coordinate inside the divider chain
  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic              ovf;
    logic [QUOT_W-1:0] quot;
  } div_lane_t;

  typedef struct packed {
    div_lane_t y;
    div_lane_t x;
    logic      row_lsb;
    logic      col_lsb;
  } div_item_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   zero;
    logic                   row_lsb;
    logic                   col_lsb;
  } cordic_item_t;

  // one restoring step: quotient bit, then doubled partial remainder
  function automatic div_lane_t div_step(input div_lane_t l, input logic [DIM_W-1:0] n);
    logic [REM_W-1:0] nn;
    logic [REM_W-1:0] diff;
    logic             ge;
    div_lane_t        o;
    nn     = {1'b0, n};
    ge     = (l.rem >= nn);
    diff   = l.rem - nn;
    o      = l;
    o.quot = {l.quot[QUOT_W-2:0], ge};
    o.rem  = ge ? {diff[REM_W-2:0], 1'b0} : {l.rem[REM_W-2:0], 1'b0};
    return o;
  endfunction

  // micro-rotation angle for one step
  function automatic logic signed [Z_W-1:0] atan_at(input logic [STEP_W-1:0] k);
    return $signed({{(Z_W-17){1'b0}}, ATAN_TAB[k]});
  endfunction

endpackage

/* sv/p2c_div_cell.sv */
// ----------------------------------------------------------------------------
// p2c_div_cell: one step of the coordinate divider chain
// Produces one quotient bit for both row and column and registers the item.
// ----------------------------------------------------------------------------
module p2c_div_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  p2c_pkg::div_item_t            item_i,
  input  logic [p2c_pkg::DIM_W-1:0]     rows_i,
  input  logic [p2c_pkg::DIM_W-1:0]     cols_i,
  output logic                          valid_o,
  output p2c_pkg::div_item_t            item_o
);
  import p2c_pkg::*;

  div_item_t item_d, item_q;
  logic      valid_q;

  // divide step on both lanes
  always_comb begin
    item_d   = item_i;
    item_d.y = div_step(item_i.y, rows_i);
    item_d.x = div_step(item_i.x, cols_i);
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
endmodule

/* sv/p2c_cordic_cell.sv */
// ----------------------------------------------------------------------------
// p2c_cordic_cell: one vectoring micro-rotation of the CORDIC chain
// Rotates toward the x axis by atan(2^-k) and accumulates the angle.
// ----------------------------------------------------------------------------
module p2c_cordic_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic [p2c_pkg::STEP_W-1:0]    step_i,
  input  logic                          valid_i,
  input  p2c_pkg::cordic_item_t         item_i,
  output logic                          valid_o,
  output p2c_pkg::cordic_item_t         item_o
);
  import p2c_pkg::*;

  cordic_item_t           item_d, item_q;
  logic                   valid_q;
  logic signed [XY_W-1:0] dx, dy;
  logic signed [Z_W-1:0]  da;

  // micro-rotation
  always_comb begin
    dx     = item_i.y >>> step_i;
    dy     = item_i.x >>> step_i;
    da     = atan_at(step_i);
    item_d = item_i;
    if (!item_i.y[XY_W-1]) begin
      item_d.x = item_i.x + dx;
      item_d.y = item_i.y - dy;
      item_d.z = item_i.z + da;
    end else begin
      item_d.x = item_i.x - dx;
      item_d.y = item_i.y + dy;
      item_d.z = item_i.z - da;
    end
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
endmodule

/* sv/p2c_index.sv */
// ----------------------------------------------------------------------------
// p2c_index: radius scaling, angle fold and index rounding
// Four stages: gain multiply, fold, index multiplies, round and clamp.
// ----------------------------------------------------------------------------
module p2c_index (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  p2c_pkg::cordic_item_t         item_i,
  input  logic [p2c_pkg::PQ_W-1:0]      p_i,
  input  logic [p2c_pkg::PQ_W-1:0]      q_i,
  output logic                          valid_o,
  output logic                          inside_res_o,
  output logic [9:0]                    proj_index_o,
  output logic [10:0]                   freq_index_o,
  output logic                          conjugate_o,
  output logic                          negate_o
);
  import p2c_pkg::*;

  localparam int PROD_W = 38;
  localparam int R_W    = PROD_W - 16;
  localparam int RF_W   = 18;
  localparam int PHI_W  = 21;
  localparam int RQ_W   = 30;
  localparam int PP_W   = 33;
  localparam int QQ_W   = RQ_W - 16;
  localparam int PI_W   = PP_W - 17;

  localparam logic signed [17:0] GAIN = 18'sd39797;

  logic v1_q, v2_q, v3_q, v4_q;

  // stage 1: gain multiply
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic signed [Z_W-1:0]    z1_q;
  logic                     zero1_q, par1_q;

  assign prod_d = PROD_W'(item_i.x) * PROD_W'(GAIN);

  // stage 2: radius rounding, disc test, fold of negative angles
  logic signed [PROD_W-1:0] rsum;
  logic signed [R_W-1:0]    r_full;
  logic signed [Z_W-1:0]    phi;
  logic signed [R_W-1:0]    r_neg;
  logic                     outside_d, outside2_q, par2_q;
  logic signed [RF_W-1:0]   rf_d, rf_q;
  logic signed [PHI_W-1:0]  phif_d, phif_q;

  always_comb begin
    rsum   = prod_q + PROD_W'(32768);
    r_full = zero1_q ? '0 : rsum[PROD_W-1:16];
    phi    = zero1_q ? '0 : z1_q;
    r_neg  = -r_full;
    outside_d = (r_full > R_W'(65536));
    if (phi[Z_W-1]) begin
      rf_d   = r_neg[RF_W-1:0];
      phif_d = PHI_W'(phi) + PHI_W'(131072);
    end else begin
      rf_d   = r_full[RF_W-1:0];
      phif_d = PHI_W'(phi);
    end
  end

  // stage 3: index multiplies
  logic signed [RQ_W-1:0] rq_d, rq_q;
  logic signed [PP_W-1:0] pp_d, pp_q;
  logic                   outside3_q, par3_q;

  assign rq_d = RQ_W'(rf_q) * RQ_W'($signed({1'b0, q_i}));
  assign pp_d = PP_W'(phif_q) * PP_W'($signed({1'b0, p_i}));

  // stage 4: rounding and clamping
  logic signed [RQ_W-1:0] qsum;
  logic signed [PP_W-1:0] psum;
  logic signed [QQ_W-1:0] qq, qs, qq_c, qq_abs;
  logic signed [PI_W-1:0] pr, ps, pr_c;
  logic                   ins_d, neg_d, conj_d;
  logic [9:0]             proj_d;
  logic [10:0]            freq_d;

  always_comb begin
    qsum = rq_q + RQ_W'(32768);
    psum = pp_q + PP_W'(65536);
    qq   = qsum[RQ_W-1:16];
    pr   = psum[PP_W-1:17];
    qs   = $signed({{(QQ_W-PQ_W){1'b0}}, q_i});
    ps   = $signed({{(PI_W-PQ_W){1'b0}}, p_i});
    priority if (qq >= qs) qq_c = qs - QQ_W'(1);
    else if (qq < -qs)     qq_c = -qs;
    else                   qq_c = qq;
    priority if (pr >= ps) pr_c = ps - PI_W'(1);
    else if (pr[PI_W-1])   pr_c = '0;
    else                   pr_c = pr;
    qq_abs = qq_c[QQ_W-1] ? -qq_c : qq_c;
    ins_d  = !outside3_q;
    proj_d = outside3_q ? '0 : pr_c[9:0];
    freq_d = outside3_q ? '0 : qq_abs[10:0];
    conj_d = !outside3_q && qq_c[QQ_W-1];
    neg_d  = !outside3_q && (qq_c[0] ^ par3_q);
  end

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // payload stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q       <= prod_d;
      z1_q         <= item_i.z;
      zero1_q      <= item_i.zero;
      par1_q       <= item_i.row_lsb ^ item_i.col_lsb;
      rf_q         <= rf_d;
      phif_q       <= phif_d;
      outside2_q   <= outside_d;
      par2_q       <= par1_q;
      rq_q         <= rq_d;
      pp_q         <= pp_d;
      outside3_q   <= outside2_q;
      par3_q       <= par2_q;
      inside_res_o <= ins_d;
      proj_index_o <= proj_d;
      freq_index_o <= freq_d;
      conjugate_o  <= conj_d;
      negate_o     <= neg_d;
    end
  end

  assign valid_o = v4_q;
endmodule

/* sv/polar_to_cartesian_gridding_top.sv */
// ----------------------------------------------------------------------------
// polar_to_cartesian_gridding_top: nearest-neighbor polar to cartesian lookup
// Throughput: one transaction per cycle unless stalled; entry, 18 divider cells, a
//   pre-rotation stage, 18 CORDIC cells and 4 index stages advance together.
// The whole chain holds while the output register is full and stalled.
// Reset: asynchronous, clears all valid flags and loads register defaults.
// ----------------------------------------------------------------------------
module polar_to_cartesian_gridding_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [10:0] row_index_i,
  input  logic [10:0] col_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        inside_res_o,
  output logic [9:0]  proj_index_o,
  output logic [10:0] freq_index_o,
  output logic        conjugate_o,
  output logic        negate_o
);
  import p2c_pkg::*;

  // configuration registers
  logic [PQ_W-1:0]  num_proj_q, half_pts_q;
  logic [DIM_W-1:0] grid_rows_q, grid_cols_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_proj_q  <= P_RESET;
      half_pts_q  <= Q_RESET;
      grid_rows_q <= H_RESET;
      grid_cols_q <= W_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_NUM_PROJ:  num_proj_q  <= cfg_data_i[PQ_W-1:0];
        CFG_HALF_PTS:  half_pts_q  <= cfg_data_i[PQ_W-1:0];
        CFG_GRID_ROWS: grid_rows_q <= cfg_data_i[DIM_W-1:0];
        CFG_GRID_COLS: grid_cols_q <= cfg_data_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // limited register values: zero reads as one, p and q saturate
  logic [PQ_W-1:0]  p_lim, q_lim;
  logic [DIM_W-1:0] h_lim, w_lim;

  always_comb begin
    priority if (num_proj_q == '0)    p_lim = PQ_W'(1);
    else if (num_proj_q > PQ_MAX)     p_lim = PQ_MAX;
    else                              p_lim = num_proj_q;
    priority if (half_pts_q == '0)    q_lim = PQ_W'(1);
    else if (half_pts_q > PQ_MAX)     q_lim = PQ_MAX;
    else                              q_lim = half_pts_q;
    h_lim = (grid_rows_q == '0) ? DIM_W'(1) : grid_rows_q;
    w_lim = (grid_cols_q == '0) ? DIM_W'(1) : grid_cols_q;
  end

  // global advance: hold everything while the result waits
  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // entry stage: load dividend and flag coordinates at or past twice the size
  div_item_t ent_d;
  div_item_t div_item [DIV_STEPS+1];
  logic      div_valid [DIV_STEPS+1];

  always_comb begin
    ent_d.y.rem  = REM_W'(row_index_i);
    ent_d.y.ovf  = (REM_W'(row_index_i) >= {h_lim, 1'b0});
    ent_d.y.quot = '0;
    ent_d.x.rem  = REM_W'(col_index_i);
    ent_d.x.ovf  = (REM_W'(col_index_i) >= {w_lim, 1'b0});
    ent_d.x.quot = '0;
    ent_d.row_lsb = row_index_i[0];
    ent_d.col_lsb = col_index_i[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_valid[0] <= 1'b0;
    end else if (en) begin
      div_valid[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      div_item[0] <= ent_d;
    end
  end

  // divider chain
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    p2c_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (div_valid[i]),
      .item_i  (div_item[i]),
      .rows_i  (h_lim),
      .cols_i  (w_lim),
      .valid_o (div_valid[i+1]),
      .item_o  (div_item[i+1])
    );
  end

  // quotient to Q2.16 coordinate, saturating just below two
  function automatic logic signed [COORD_W-1:0] to_coord(input div_lane_t l);
    logic [COORD_W:0] c;
    c = {1'b0, l.quot} - (COORD_W+1)'(65536);
    if (l.ovf || (l.quot[QUOT_W-1] && l.quot[QUOT_W-2])) begin
      return COORD_W'(131071);
    end
    return $signed(c[COORD_W-1:0]);
  endfunction

  // pre-rotation stage: bring x to the right half plane
  logic signed [COORD_W-1:0] yc, xc;
  cordic_item_t              pre_d;
  cordic_item_t              cor_item [CORDIC_STEPS+1];
  logic                      cor_valid [CORDIC_STEPS+1];

  always_comb begin
    yc = to_coord(div_item[DIV_STEPS].y);
    xc = to_coord(div_item[DIV_STEPS].x);
    pre_d.zero    = (xc == '0) && (yc == '0);
    pre_d.row_lsb = div_item[DIV_STEPS].row_lsb;
    pre_d.col_lsb = div_item[DIV_STEPS].col_lsb;
    pre_d.x       = XY_W'(xc);
    pre_d.y       = XY_W'(yc);
    pre_d.z       = '0;
    if (xc[COORD_W-1]) begin
      if (!yc[COORD_W-1]) begin
        pre_d.x = XY_W'(yc);
        pre_d.y = -XY_W'(xc);
        pre_d.z = HALF_PI;
      end else begin
        pre_d.x = -XY_W'(yc);
        pre_d.y = XY_W'(xc);
        pre_d.z = -HALF_PI;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cor_valid[0] <= 1'b0;
    end else if (en) begin
      cor_valid[0] <= div_valid[DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cor_item[0] <= pre_d;
    end
  end

  // CORDIC chain
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    p2c_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .step_i  (STEP_W'(k)),
      .valid_i (cor_valid[k]),
      .item_i  (cor_item[k]),
      .valid_o (cor_valid[k+1]),
      .item_o  (cor_item[k+1])
    );
  end

  // radius, fold and index stages with the output register
  p2c_index u_index (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (cor_valid[CORDIC_STEPS]),
    .item_i       (cor_item[CORDIC_STEPS]),
    .p_i          (p_lim),
    .q_i          (q_lim),
    .valid_o      (out_valid_o),
    .inside_res_o (inside_res_o),
    .proj_index_o (proj_index_o),
    .freq_index_o (freq_index_o),
    .conjugate_o  (conjugate_o),
    .negate_o     (negate_o)
  );
endmodule

/* dv/polar_to_cartesian_gridding_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// polar_to_cartesian_gridding_checker: result prediction and comparison
// Watches the input and output channels and the register write port, keeps
// its own copy of the registers, computes the expected lookup address for
// each accepted position and compares every accepted result in order.
// ----------------------------------------------------------------------------
module polar_to_cartesian_gridding_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic [10:0] row_index_i,
  input  logic [10:0] col_index_i,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic        inside_res_o,
  input  logic [9:0]  proj_index_o,
  input  logic [10:0] freq_index_o,
  input  logic        conjugate_o,
  input  logic        negate_o,
  output int          fail_count,
  output int          pending_count
);
  import p2c_pkg::*;

  typedef struct packed {
    logic        in_disc;
    logic [9:0]  proj;
    logic [10:0] freq;
    logic        conj;
    logic        neg;
  } lookup_t;

  lookup_t     lookup_q[$];
  logic [10:0] proj_count;
  logic [10:0] half_count;
  logic [11:0] rows;
  logic [11:0] cols;

  localparam int ATAN_PI [18] = '{32768, 19344, 10221, 5188, 2604, 1303, 652, 326,
                                  163, 81, 41, 20, 10, 5, 3, 1, 1, 0};

  assign pending_count = lookup_q.size();

  function automatic longint floor_shift(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint clip_reg(longint v, longint hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint grid_coord(longint idx, longint n);
    longint c;
    c = (idx * 131072) / n - 65536;
    if (c > 131071) c = 131071;
    return c;
  endfunction

  function automatic lookup_t compute_lookup(logic [10:0] row, logic [10:0] col);
    longint p, q, yy, xx, x, y, z, r, phi, qq, pp, t, dx, dy;
    lookup_t res;
    p   = clip_reg(proj_count, 1024);
    q   = clip_reg(half_count, 1024);
    yy  = grid_coord(row, clip_reg(rows, 4095));
    xx  = grid_coord(col, clip_reg(cols, 4095));
    x   = xx;
    y   = yy;
    z   = 0;
    r   = 0;
    phi = 0;
    res = '0;
    if (x != 0 || y != 0) begin
      if (x < 0) begin
        t = x;
        if (y >= 0) begin
          x = y; y = -t; z = 65536;
        end else begin
          x = -y; y = t; z = -65536;
        end
      end
      for (int k = 0; k < 18; k++) begin
        dx = floor_shift(y, k);
        dy = floor_shift(x, k);
        if (y >= 0) begin
          x += dx; y -= dy; z += ATAN_PI[k];
        end else begin
          x -= dx; y += dy; z -= ATAN_PI[k];
        end
      end
      r   = floor_shift(x * 39797 + 32768, 16);
      phi = z;
    end
    if (r > 65536) return res;
    // fold lower half plane onto negative radius
    if (phi < 0) begin
      r   = -r;
      phi += 131072;
    end
    qq = floor_shift(r * q + 32768, 16);
    if (qq >= q) qq = q - 1;
    if (qq < -q) qq = -q;
    pp = floor_shift(phi * p + 65536, 17);
    if (pp >= p) pp = p - 1;
    if (pp < 0) pp = 0;
    res.in_disc = 1'b1;
    res.proj    = pp[9:0];
    res.freq    = (qq < 0) ? 11'(-qq) : 11'(qq);
    res.conj    = qq < 0;
    res.neg     = qq[0] ^ row[0] ^ col[0];
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // register shadow, prediction and comparison
  always @(posedge clk_i or negedge rst_ni) begin
    lookup_t want;
    if (!rst_ni) begin
      proj_count = P_RESET;
      half_count = Q_RESET;
      rows       = H_RESET;
      cols       = W_RESET;
      fail_count = 0;
      lookup_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_NUM_PROJ:  proj_count = cfg_data_i[10:0];
          CFG_HALF_PTS:  half_count = cfg_data_i[10:0];
          CFG_GRID_ROWS: rows       = cfg_data_i;
          CFG_GRID_COLS: cols       = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o)
        lookup_q.push_back(compute_lookup(row_index_i, col_index_i));
      if (out_valid_o && !out_stall_i) begin
        if (lookup_q.size() == 0) begin
          report_mismatch("unexpected transaction", 1, 0);
        end else begin
          want = lookup_q.pop_front();
          if (inside_res_o !== want.in_disc)
            report_mismatch("inside_res", inside_res_o, want.in_disc);
          if (proj_index_o !== want.proj) report_mismatch("proj_index", proj_index_o, want.proj);
          if (freq_index_o !== want.freq) report_mismatch("freq_index", freq_index_o, want.freq);
          if (conjugate_o !== want.conj) report_mismatch("conjugate", conjugate_o, want.conj);
          if (negate_o !== want.neg) report_mismatch("negate", negate_o, want.neg);
        end
      end
    end
  end

endmodule

/* dv/polar_to_cartesian_gridding_top_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// polar_to_cartesian_gridding_top_test: testbench for the gridding lookup
// Drives grid positions under several register settings and idle patterns,
// including a long output hold-off; the checker predicts and compares.
// ----------------------------------------------------------------------------
module polar_to_cartesian_gridding_top_test;
  import p2c_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [11:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [10:0] row_index_i = '0;
  logic [10:0] col_index_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        inside_res_o;
  logic [9:0]  proj_index_o;
  logic [10:0] freq_index_o;
  logic        conjugate_o;
  logic        negate_o;
  int          fail_count;
  int          pending_count;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  bit          hold_off = 1'b0;

  always #1 clk_i = ~clk_i;

  polar_to_cartesian_gridding_top dut (.*);
  polar_to_cartesian_gridding_checker checker_i (.*);

  // receiver stall pattern, with an optional long hold-off
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        out_stall_i <= 1'b1;
        repeat (150) @(negedge clk_i);
        hold_off = 1'b0;
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [11:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_grid(logic [11:0] p, logic [11:0] q, logic [11:0] h, logic [11:0] w);
    write_reg(CFG_NUM_PROJ, p);
    write_reg(CFG_HALF_PTS, q);
    write_reg(CFG_GRID_ROWS, h);
    write_reg(CFG_GRID_COLS, w);
  endtask

  // send one position; valid held until accepted
  task automatic send_position(logic [10:0] row, logic [10:0] col);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    row_index_i <= row;
    col_index_i <= col;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
  endtask

  // random positions, mostly inside the configured grid
  task automatic random_phase(int n, int idle, int stall, logic [11:0] h, logic [11:0] w);
    send_idle_pct = idle;
    stall_pct     = stall;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 8)
        send_position(11'($urandom_range((h == 0 ? 1 : h) - 1)),
                      11'($urandom_range((w == 0 ? 1 : w) - 1)));
      else
        send_position(11'($urandom), 11'($urandom));
    end
    drain();
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    // directed: reset settings, corners, center, beyond grid
    send_position(0, 0);
    send_position(100, 100);
    send_position(100, 0);
    send_position(0, 100);
    send_position(199, 199);
    send_position(100, 199);
    send_position(199, 100);
    send_position(150, 50);
    send_position(50, 150);
    send_position(2047, 2047);
    send_position(1365, 682);
    drain();
    // zero registers act as one
    set_grid(0, 0, 0, 0);
    send_position(0, 0);
    send_position(1, 1);
    send_position(0, 1);
    drain();
    // oversized p and q saturate
    set_grid(12'd2047, 12'd2047, 12'd2048, 12'd2048);
    send_position(1024, 1024);
    send_position(1024, 2047);
    send_position(1023, 1500);
    send_position(1500, 700);
    send_position(300, 1024);
    drain();
    set_grid(12'd4095, 12'd1024, 12'd4095, 12'd4095);
    send_position(2047, 2047);
    send_position(0, 2047);
    drain();

    set_grid(12'd1024, 12'd1024, 12'd2048, 12'd2048);
    random_phase(120, 0, 0, 12'd2048, 12'd2048);
    set_grid(12'd1, 12'd1, 12'd3, 12'd5);
    random_phase(100, 76, 0, 12'd3, 12'd5);
    set_grid(12'd180, 12'd64, 12'd128, 12'd256);
    random_phase(100, 0, 76, 12'd128, 12'd256);
    set_grid(12'($urandom_range(1, 1024)), 12'($urandom_range(1, 1024)),
             12'd200, 12'd200);
    random_phase(100, 15, 15, 12'd200, 12'd200);
    // long output hold-off while sending back to back
    set_grid(12'd360, 12'd512, 12'd64, 12'd64);
    hold_off = 1'b1;
    random_phase(180, 0, 0, 12'd64, 12'd64);

    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
